[rtl/kmms_pkg.sv]
// ----------------------------------------------------------------------------
// kmms_pkg
// Shared types and defaults for the k-way merge minimum-select block.
// ----------------------------------------------------------------------------
package kmms_pkg;

   localparam int KMMS_LISTS       = 8;
   localparam int KMMS_QUEUE_DEPTH = 16;
   localparam int KMMS_VALUE_W     = 32;
   localparam int KMMS_QINDEX_W    = 3;

   typedef logic signed [KMMS_VALUE_W-1:0] value_type;
   typedef logic [KMMS_QINDEX_W-1:0]       qindex_type;

   typedef enum logic {
      OP_APPEND = 1'b0,
      OP_TAKE   = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_POP
   } state_type;

endpackage

[rtl/kmms_if.sv]
// ----------------------------------------------------------------------------
// kmms_req_if / kmms_rsp_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface kmms_req_if;
   import kmms_pkg::*;

   logic       valid;
   logic       ready;
   op_type     op;
   qindex_type queue_index;
   value_type  in_value;

   modport source (output valid, output op, output queue_index, output in_value,
                   input ready);
   modport sink   (input valid, input op, input queue_index, input in_value,
                   output ready);
endinterface

interface kmms_rsp_if;
   import kmms_pkg::*;

   logic       valid;
   logic       ready;
   value_type  out_value;
   qindex_type out_queue;
   logic       out_valid;
   logic       out_full;

   modport source (output valid, output out_value, output out_queue,
                   output out_valid, output out_full, input ready);
   modport sink   (input valid, input out_value, input out_queue,
                   input out_valid, input out_full, output ready);
endinterface

[rtl/kway_merge_min_select.sv]
// ----------------------------------------------------------------------------
// kway_merge_min_select
// K-way merge: LISTS sorted queues in one memory, take returns smallest head.
// ----------------------------------------------------------------------------
// Each item yields exactly one result. An append is accepted, then writes
// the queue memory and updates the counters. A take is accepted, runs the
// compare tree over the cached queue heads and registers the winner, then
// pops the winner and issues the memory read of its next head; that read
// returns during the following idle cycle and refreshes the head cache
// before any later take reaches the compare tree. The queue memory has one
// write port and one read port, and the tree spans LISTS cached heads.
// Results wait in a one-deep output slot, so a new item is accepted while
// the previous result is still pending; an item finishes only once that
// slot is free. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module kway_merge_min_select #(
   parameter int LISTS       = kmms_pkg::KMMS_LISTS,
   parameter int QUEUE_DEPTH = kmms_pkg::KMMS_QUEUE_DEPTH
) (
   input logic        clock,
   input logic        reset,
   kmms_req_if.sink   req_if,
   kmms_rsp_if.source rsp_if
);
   import kmms_pkg::*;

   localparam int QW = $clog2(LISTS);
   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int AW = $clog2(LISTS * QUEUE_DEPTH);

   // Step a ring slot forward within one queue's region.
   function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] base,
                                              input logic [PW-1:0] offset);
      logic [PW:0] sum;
      sum = {1'b0, base} + {1'b0, offset};
      if (sum >= (PW+1)'(QUEUE_DEPTH)) begin
         sum = sum - (PW+1)'(QUEUE_DEPTH);
      end
      return sum[PW-1:0];
   endfunction

   // FSM and held item
   state_type  state_ff, state_in;
   op_type     item_op_ff;
   qindex_type item_qi_ff;
   value_type  item_val_ff;

   // Per-queue control state and head cache
   logic [PW-1:0] head_ptr_ff [LISTS];
   logic [CW-1:0] fill_ff     [LISTS];
   value_type     head_val_ff [LISTS];
   logic          leaf_vld    [LISTS];

   // Compare tree winner
   logic          tree_vld;
   value_type     tree_val;
   logic [QW-1:0] tree_q;
   logic          win_vld_ff;
   value_type     win_val_ff;
   logic [QW-1:0] win_q_ff;

   // Head refill in flight
   logic          refill_pend_ff;
   logic [QW-1:0] refill_q_ff;

   // Control decoded from the state
   logic          accept;
   logic          slot_free;
   logic          exec_append;
   logic          exec_take;
   logic          pop_done;
   logic          app_ok;
   logic [QW-1:0] app_idx;
   logic [PW-1:0] app_slot;
   logic [PW-1:0] pop_next;
   logic          rsp_load;
   value_type     rsp_value;
   qindex_type    rsp_queue;
   logic          rsp_found;
   logic          rsp_full;

   // Memory ports
   logic            ram_wr_en;
   logic [AW-1:0]   ram_wr_addr;
   logic            ram_rd_en;
   logic [AW-1:0]   ram_rd_addr;
   logic [KMMS_VALUE_W-1:0] ram_rd_data;

   assign accept = req_if.valid && req_if.ready;

   for (genvar j = 0; j < LISTS; j++) begin : g_leaf
      assign leaf_vld[j] = (fill_ff[j] != '0);
   end

   kmms_min_select #(
      .LISTS (LISTS),
      .QW    (QW)
   ) u_min_select (
      .leaf_vld (leaf_vld),
      .leaf_val (head_val_ff),
      .win_vld  (tree_vld),
      .win_val  (tree_val),
      .win_q    (tree_q)
   );

   kmms_queue_ram #(
      .DEPTH (LISTS * QUEUE_DEPTH),
      .WIDTH (KMMS_VALUE_W)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (item_val_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   kmms_gate u_gate (
      .clock     (clock),
      .reset     (reset),
      .load      (rsp_load),
      .value     (rsp_value),
      .queue     (rsp_queue),
      .found     (rsp_found),
      .full      (rsp_full),
      .slot_free (slot_free),
      .rsp_if    (rsp_if)
   );

   // Append target: numbers at or beyond LISTS are refused like a full queue.
   assign app_idx  = QW'(item_qi_ff);
   assign app_ok   = (32'(item_qi_ff) < LISTS) &&
                     (fill_ff[app_idx] < CW'(QUEUE_DEPTH));
   assign app_slot = ring_add(head_ptr_ff[app_idx], PW'(fill_ff[app_idx]));
   assign pop_next = ring_add(head_ptr_ff[win_q_ff], PW'(1));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (item_op_ff == OP_TAKE) begin
               state_in = ST_POP;
            end else if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_POP: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs of the state
   always_comb begin
      req_if.ready = 1'b0;
      exec_append  = 1'b0;
      exec_take    = 1'b0;
      pop_done     = 1'b0;
      rsp_load     = 1'b0;
      rsp_value    = '0;
      rsp_queue    = '0;
      rsp_found    = 1'b0;
      rsp_full     = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = AW'(app_idx) * AW'(QUEUE_DEPTH) + AW'(app_slot);
      ram_rd_en    = 1'b0;
      ram_rd_addr  = AW'(win_q_ff) * AW'(QUEUE_DEPTH) + AW'(pop_next);
      case (state_ff)
         ST_IDLE: begin
            req_if.ready = 1'b1;
         end
         ST_EXEC: begin
            if (item_op_ff == OP_TAKE) begin
               exec_take = 1'b1;
            end else if (slot_free) begin
               exec_append = 1'b1;
               ram_wr_en   = app_ok;
               rsp_load    = 1'b1;
               rsp_queue   = item_qi_ff;
               rsp_full    = !app_ok;
            end
         end
         ST_POP: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               if (win_vld_ff) begin
                  pop_done  = 1'b1;
                  rsp_value = win_val_ff;
                  rsp_queue = KMMS_QINDEX_W'(win_q_ff);
                  rsp_found = 1'b1;
                  // Fetch the next head only if one remains behind this one.
                  ram_rd_en = (fill_ff[win_q_ff] > CW'(1));
               end
            end
         end
         default: begin
            req_if.ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         refill_pend_ff <= 1'b0;
         for (int j = 0; j < LISTS; j++) begin
            head_ptr_ff[j] <= '0;
            fill_ff[j]     <= '0;
         end
      end else begin
         state_ff       <= state_in;
         refill_pend_ff <= ram_rd_en;
         if (exec_append && app_ok) begin
            fill_ff[app_idx] <= fill_ff[app_idx] + CW'(1);
         end
         if (pop_done) begin
            head_ptr_ff[win_q_ff] <= pop_next;
            fill_ff[win_q_ff]     <= fill_ff[win_q_ff] - CW'(1);
         end
      end
   end

   // Payload registers: held item, winner, head cache
   always_ff @(posedge clock) begin
      if (accept) begin
         item_op_ff  <= req_if.op;
         item_qi_ff  <= req_if.queue_index;
         item_val_ff <= req_if.in_value;
      end
      if (exec_take) begin
         win_vld_ff <= tree_vld;
         win_val_ff <= tree_val;
         win_q_ff   <= tree_q;
      end
      if (ram_rd_en) begin
         refill_q_ff <= win_q_ff;
      end
      // An append to an empty queue becomes its head directly.
      if (exec_append && app_ok && (fill_ff[app_idx] == '0)) begin
         head_val_ff[app_idx] <= item_val_ff;
      end
      // Land the refilled head; the queue is non-empty, so no append clashes.
      if (refill_pend_ff) begin
         head_val_ff[refill_q_ff] <= ram_rd_data;
      end
   end

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   // The head cache must be settled before the tree samples it.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |-> !refill_pend_ff)
      else $error("compare tree sampled a head that is still being refilled");

   // The registered winner must still be a non-empty queue when it is popped.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP && win_vld_ff) |-> (fill_ff[win_q_ff] != '0))
      else $error("pop of an empty queue");

   // A refill read is only issued for the winner of a found take.
   assert property (@(posedge clock) disable iff (reset)
      ram_rd_en |-> (pop_done && rsp_found))
      else $error("queue memory read outside a pop");

   // After a pop, the head refill lands in the very next cycle.
   assert property (@(posedge clock) disable iff (reset)
      ram_rd_en |=> (refill_pend_ff && state_ff == ST_IDLE))
      else $error("head refill did not land in the idle cycle");

endmodule

[rtl/kmms_queue_ram.sv]
// ----------------------------------------------------------------------------
// kmms_queue_ram
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module kmms_queue_ram #(
   parameter int DEPTH = 128,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/kmms_min_select.sv]
// ----------------------------------------------------------------------------
// kmms_min_select
// Compare tree over the cached queue heads; lowest queue number wins ties.
// ----------------------------------------------------------------------------
module kmms_min_select #(
   parameter int LISTS = 8,
   parameter int QW    = 3
) (
   input  logic                    leaf_vld [LISTS],
   input  kmms_pkg::value_type     leaf_val [LISTS],
   output logic                    win_vld,
   output kmms_pkg::value_type     win_val,
   output logic [QW-1:0]           win_q
);
   import kmms_pkg::*;

   localparam int LEVELS = $clog2(LISTS);
   localparam int LEAVES = 2 ** LEVELS;
   localparam int NODES  = 2 * LEAVES - 1;

   logic          node_vld [NODES];
   value_type     node_val [NODES];
   logic [QW-1:0] node_q   [NODES];

   for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
      if (j < LISTS) begin : g_used
         assign node_vld[LEAVES-1+j] = leaf_vld[j];
         assign node_val[LEAVES-1+j] = leaf_val[j];
         assign node_q[LEAVES-1+j]   = QW'(j);
      end else begin : g_pad
         assign node_vld[LEAVES-1+j] = 1'b0;
         assign node_val[LEAVES-1+j] = '0;
         assign node_q[LEAVES-1+j]   = '0;
      end
   end

   // Left child holds the lower queue numbers: keep it on equal values.
   for (genvar i = 0; i < LEAVES - 1; i++) begin : g_node
      logic take_left;
      assign take_left = node_vld[2*i+1] &&
                         (!node_vld[2*i+2] || (node_val[2*i+1] <= node_val[2*i+2]));
      assign node_vld[i] = node_vld[2*i+1] || node_vld[2*i+2];
      assign node_val[i] = take_left ? node_val[2*i+1] : node_val[2*i+2];
      assign node_q[i]   = take_left ? node_q[2*i+1]   : node_q[2*i+2];
   end

   assign win_vld = node_vld[0];
   assign win_val = node_val[0];
   assign win_q   = node_q[0];
endmodule

[rtl/kmms_top_placeholder_never_used.sv]
// ----------------------------------------------------------------------------
// kmms_gate
// Output slot of the result channel: holds one result until it is taken.
// ----------------------------------------------------------------------------
module kmms_gate (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  kmms_pkg::value_type    value,
   input  kmms_pkg::qindex_type   queue,
   input  logic                   found,
   input  logic                   full,
   output logic                   slot_free,
   kmms_rsp_if.source             rsp_if
);
   import kmms_pkg::*;

   logic       rsp_valid_ff, rsp_valid_in;
   value_type  rsp_value_ff;
   qindex_type rsp_queue_ff;
   logic       rsp_found_ff;
   logic       rsp_full_ff;

   assign slot_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_value_ff <= value;
         rsp_queue_ff <= queue;
         rsp_found_ff <= found;
         rsp_full_ff  <= full;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.out_value = rsp_value_ff;
   assign rsp_if.out_queue = rsp_queue_ff;
   assign rsp_if.out_valid = rsp_found_ff;
   assign rsp_if.out_full  = rsp_full_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_found_ff && rsp_full_ff))
      else $error("result marks both a found value and a full queue");
endmodule
